// ===== hdl/ir_pulse_width_key_decoder_core_macros.svh =====
// Assertion macros for the IR key decoder checker.
// Include guard only; no dependencies.
`ifndef IR_PULSE_WIDTH_KEY_DECODER_CORE_MACROS_SVH
`define IR_PULSE_WIDTH_KEY_DECODER_CORE_MACROS_SVH

// Generic clocked assertion with an explicit clock and active-low reset.
`define IRKD_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the core clock and reset.
`define IRKD_ASSERT(label, prop, msg) \
  `IRKD_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== hdl/irkd_pkg.sv =====
// Shared types, constants and key table for the IR pulse-width key decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package irkd_pkg;

  localparam int FRAME_BITS     = 32;
  localparam int KEY_COUNT      = 10;
  localparam int KEY_TABLE_SIZE = 10;
  localparam int KEY_SCAN       = (KEY_COUNT < KEY_TABLE_SIZE) ? KEY_COUNT : KEY_TABLE_SIZE;

  localparam int TIME_W  = 32;
  localparam int GAP_W   = 31;
  localparam int COUNT_W = 5;
  localparam int KEY_W   = 4;

  localparam logic [GAP_W-1:0] MAX_GAP_RESET       = 31'd100000;
  localparam logic [GAP_W-1:0] ONE_THRESHOLD_RESET = 31'd25000;

  localparam logic [31:0] KEY_CODES [KEY_TABLE_SIZE] = '{
    32'hE916FF00, 32'hF30CFF00, 32'hE718FF00, 32'hA15EFF00, 32'hF708FF00,
    32'hE31CFF00, 32'hA55AFF00, 32'hBD42FF00, 32'hAD52FF00, 32'hB54AFF00
  };

  typedef enum logic {
    CMD_EDGE = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_MAX_GAP       = 1'b0,
    REG_ONE_THRESHOLD = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [GAP_W-1:0] max_gap;
    logic [GAP_W-1:0] one_threshold;
  } irkd_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]     last_edge;
    logic [FRAME_BITS-1:0] code;
    logic [COUNT_W-1:0]    bit_count;
    logic                  pending;
    logic [KEY_W-1:0]      key;
  } irkd_state_t;

  typedef struct packed {
    logic               key_valid;
    logic [KEY_W-1:0]   key_value;
    logic [COUNT_W-1:0] bits_received;
  } irkd_result_t;

endpackage

`default_nettype wire

// ===== hdl/irkd_cfg.sv =====
// Configuration registers: max gap and one threshold.
// Depends on irkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irkd_cfg import irkd_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [0:0]       cfg_idx_i,
  input  wire logic [GAP_W-1:0] cfg_wdata_i,
  output irkd_cfg_t             cfg_o
);

  logic [GAP_W-1:0] max_gap_q;
  logic [GAP_W-1:0] one_thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_gap_q <= MAX_GAP_RESET;
      one_thr_q <= ONE_THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MAX_GAP:       max_gap_q <= cfg_wdata_i;
        REG_ONE_THRESHOLD: one_thr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o.max_gap       = max_gap_q;
  assign cfg_o.one_threshold = one_thr_q;

endmodule

`default_nettype wire

// ===== hdl/irkd_step.sv =====
// Per-item decode logic: gap classification, bit shift-in, key match, read.
// Depends on irkd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module irkd_step import irkd_pkg::*; (
  input  wire cmd_e               cmd_i,
  input  wire logic [TIME_W-1:0]  edge_time_i,
  input  wire irkd_cfg_t          cfg_i,
  input  wire irkd_state_t        state_i,
  output irkd_state_t             state_o,
  output irkd_result_t            result_o
);

  logic [TIME_W-1:0]     diff;
  logic                  negative;
  logic                  restart;
  logic                  bit_one;
  logic [FRAME_BITS-1:0] code_set;
  logic [COUNT_W:0]      count_inc;
  logic                  frame_done;
  logic                  hit;
  logic [KEY_W-1:0]      hit_idx;

  always_comb begin
    diff       = edge_time_i - state_i.last_edge;
    negative   = diff[TIME_W-1];
    restart    = !negative && (diff[GAP_W-1:0] > cfg_i.max_gap);
    bit_one    = !negative && (diff[GAP_W-1:0] > cfg_i.one_threshold);
    code_set   = state_i.code |
                 (bit_one ? (FRAME_BITS'(1) << state_i.bit_count) : '0);
    count_inc  = {1'b0, state_i.bit_count} + (COUNT_W+1)'(1);
    frame_done = count_inc >= (COUNT_W+1)'(FRAME_BITS);
  end

  // Scan from the top so the lowest matching index wins.
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = KEY_SCAN - 1; i >= 0; i--) begin
      if (code_set == KEY_CODES[i][FRAME_BITS-1:0]) begin
        hit     = 1'b1;
        hit_idx = KEY_W'(i);
      end
    end
  end

  always_comb begin
    state_o            = state_i;
    result_o.key_valid = state_i.pending;
    case (cmd_i)
      CMD_EDGE: begin
        state_o.last_edge = edge_time_i;
        if (restart || frame_done) begin
          state_o.code      = '0;
          state_o.bit_count = '0;
          if (!restart && hit) begin
            state_o.key     = hit_idx;
            state_o.pending = 1'b1;
          end
        end else begin
          state_o.code      = code_set;
          state_o.bit_count = count_inc[COUNT_W-1:0];
        end
        result_o.key_valid = state_o.pending;
      end
      CMD_READ: begin
        state_o.pending = 1'b0;
      end
      default: ;
    endcase
    result_o.key_value     = state_o.key;
    result_o.bits_received = state_o.bit_count;
  end

endmodule

`default_nettype wire

// ===== hdl/ir_pulse_width_key_decoder_core.sv =====
// Top level of the IR pulse-width key decoder: input register, decoder state,
// result register. Depends on irkd_pkg, irkd_cfg and irkd_step.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------------
//  in      | to core   | in_valid_i / in_stall_o   | cmd_i, edge_time_i
//  out     | from core | out_valid_o / out_stall_i | key_valid_o, key_value_o,
//          |           |                           | bits_received_o
//  cfg     | to core   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while out_stall_i is low; each taken item passes through
// the input register, where the decode logic works on it, and then into the result
// register once that register is free.
// in_stall_o rises only when both registers hold items and out_stall_i is high.
// Reset clears the valid flags and decoder state and loads the default thresholds.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_key_decoder_core import irkd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_idx_i,
  input  wire logic [GAP_W-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [0:0]         cmd_i,
  input  wire logic [TIME_W-1:0]  edge_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    key_valid_o,
  output logic [KEY_W-1:0]        key_value_o,
  output logic [COUNT_W-1:0]      bits_received_o
);

  irkd_cfg_t    cfg;
  irkd_state_t  state_q, state_d;
  irkd_result_t result_q, result_d;

  logic              in_valid_q;
  cmd_e              cmd_q;
  logic [TIME_W-1:0] edge_time_q;
  logic              out_valid_q;
  logic              advance;
  logic              in_take;

  irkd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  irkd_step u_step (
    .cmd_i       (cmd_q),
    .edge_time_i (edge_time_q),
    .cfg_i       (cfg),
    .state_i     (state_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  // Move the held item into the result register when that register frees up.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take || advance) begin
      in_valid_q <= in_take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q       <= cmd_e'(cmd_i);
      edge_time_q <= edge_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign key_valid_o     = result_q.key_valid;
  assign key_value_o     = result_q.key_value;
  assign bits_received_o = result_q.bits_received;

endmodule

`default_nettype wire

// ===== hdl/irkd_checker.sv =====
// Port-level checker for the IR key decoder core, bound to the top level.
// Depends on irkd_pkg and ir_pulse_width_key_decoder_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "ir_pulse_width_key_decoder_core_macros.svh"

module irkd_checker import irkd_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               key_valid_o,
  input wire logic [KEY_W-1:0]   key_value_o,
  input wire logic [COUNT_W-1:0] bits_received_o
);

  logic                       in_acc;
  logic                       out_acc;
  logic [1:0]                 inflight_q;
  logic [KEY_W+COUNT_W:0]     out_bits;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_acc  = out_valid_o && !out_stall_i;
  assign out_bits = {key_valid_o, key_value_o, bits_received_o};

  // Track items taken but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else if (in_acc && !out_acc) begin
      inflight_q <= inflight_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      inflight_q <= inflight_q - 2'd1;
    end
  end

  `IRKD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_bits), "stalled result changed")
  `IRKD_ASSERT(a_out_has_item, out_valid_o |-> inflight_q != 2'd0, "result without a pending item")
  `IRKD_ASSERT(a_inflight_bound, inflight_q != 2'd3, "more than two items in flight")
  `IRKD_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while output free")

endmodule

bind ir_pulse_width_key_decoder_core irkd_checker u_irkd_checker (.*);

`default_nettype wire
